>>> rtl/tqp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqp_pkg
// Shared types and constants for the ternary quantizer, packer and im2col
// reader.
// ----------------------------------------------------------------------------
package tqp_pkg;

  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;
  localparam int SAMPLE_W  = 16;
  localparam int THRESH_W  = 15;
  localparam int GEOM_W    = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PULL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_COLS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_ROWS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_COLS = 3'd6;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

>>> rtl/ternary_quantize_pack_im2col.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ternary_quantize_pack_im2col
// Quantizes an image to ternary bit planes, stores 64 channels per word pair
// for each pixel, and reads the pairs back in im2col order.
//
//   channel  direction  handshake        payload
//   in_      in         valid / stall    opcode, sample, end flags
//   out_     out        valid / stall    neg/nonzero planes, status bits
//   cfg_     in         valid / ready    index, data (ready always high)
//
// Loads and pulls can be accepted back to back; a load that flushes a block
// writes the store in its accept cycle. A pull reads the store at accept and
// its beat is presented the next cycle from the store's read register, so one
// beat can follow another back to back. A pull is held off only while a beat
// waits and out_stall is high. Reset returns all control state to its
// defaults; the pixel store is not cleared.
module ternary_quantize_pack_im2col import tqp_pkg::*; #(
  parameter int MAX_CHANNELS = 256,
  parameter int MAX_COLS     = 32,
  parameter int MAX_ROWS     = 32,
  parameter int MAX_KERNEL   = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_opcode,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_end_of_pixel,
  input  logic                       in_end_of_row,
  input  logic                       in_end_of_image,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [WORD_BITS-1:0]       out_neg_plane,
  output logic [WORD_BITS-1:0]       out_nonzero_plane,
  output logic                       out_last,
  output logic                       out_exhausted,
  output logic                       out_size_overflow,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [THRESH_W-1:0]        cfg_data
);

  localparam int BLOCKS  = (MAX_CHANNELS + WORD_BITS - 1) / WORD_BITS;
  localparam int BW      = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW      = RW + CW + BW;
  localparam int CH_W    = $clog2(MAX_CHANNELS + 1);
  localparam int ROWS_W  = $clog2(MAX_ROWS + 1);
  localparam int COLS_W  = $clog2(MAX_COLS + 1);
  localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int CRD_W   = $clog2(MAX_DIM + 32) + 1;
  localparam int KCL     = (MAX_KERNEL > 7) ? 7 : MAX_KERNEL;

  localparam logic [CH_W-1:0]   MAX_CH_V   = CH_W'(MAX_CHANNELS);
  localparam logic [CH_W-1:0]   LAST_CH_V  = CH_W'(MAX_CHANNELS - 1);
  localparam logic [ROWS_W-1:0] MAX_ROWS_V = ROWS_W'(MAX_ROWS);
  localparam logic [COLS_W-1:0] MAX_COLS_V = COLS_W'(MAX_COLS);
  localparam logic [GEOM_W-1:0] KCL_V      = GEOM_W'(KCL);

  // Configuration registers.
  logic [THRESH_W-1:0] threshold_r;
  logic [GEOM_W-1:0]   pad_rows_r, pad_cols_r, kern_rows_r, kern_cols_r;
  logic [GEOM_W-1:0]   strd_rows_r, strd_cols_r;

  // Geometry latched at the end of each image.
  logic [GEOM_W-1:0]   g_pr_r, g_pc_r, g_kr_r, g_kc_r, g_sr_r, g_sc_r;
  logic [GEOM_W-1:0]   g_pr_nxt, g_pc_nxt, g_kr_nxt, g_kc_nxt, g_sr_nxt, g_sc_nxt;

  // Load side.
  logic [WORD_BITS-1:0] neg_acc_r, nz_acc_r, neg_acc_nxt, nz_acc_nxt;
  logic [CH_W-1:0]      ccnt_r, ccnt_nxt;
  logic [COLS_W-1:0]    lcol_r, lcol_nxt, img_cols_r, img_cols_nxt;
  logic [ROWS_W-1:0]    lrow_r, lrow_nxt, img_rows_r, img_rows_nxt;
  logic [CH_W-1:0]      img_chans_r, img_chans_nxt;
  logic                 ovf_r, ovf_nxt, done_r, done_nxt, rdone_r, rdone_nxt;

  // Readout counters; window origins are stepped by the stride.
  logic [CRD_W-1:0]  ybase_r, ybase_nxt, xbase_r, xbase_nxt;
  logic [GEOM_W-1:0] kh_r, kh_nxt, kw_r, kw_nxt;
  logic [BW-1:0]     blk_r, blk_nxt;

  // Output beat.
  logic out_valid_r, out_valid_nxt;
  logic hit_r, hit_nxt, last_r, last_nxt, exh_r, exh_nxt, sovf_r, sovf_nxt;

  logic in_acc, load_acc, pull_acc;
  assign in_acc   = in_valid && !in_stall;
  assign load_acc = in_acc && (in_opcode == OP_LOAD);
  assign pull_acc = in_acc && (in_opcode == OP_PULL);
  assign in_stall = (in_opcode == OP_PULL) && out_valid_r && out_stall;
  assign cfg_ready = 1'b1;

  // Store interface.
  mem_ctl_t               mem_ctl;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic [2*WORD_BITS-1:0] wr_data, rd_data;

  // Load datapath signals.
  logic                 eoi, eor, eop;
  logic [CH_W-1:0]      ccnt_e;
  logic [COLS_W-1:0]    lcol_e;
  logic [ROWS_W-1:0]    lrow_e;
  logic [WORD_BITS-1:0] neg_e, nz_e, mask;
  logic                 pix_ok, ch_ok, flush;
  logic signed [SAMPLE_W:0] s_ext, t_ext;

  // Pull datapath signals.
  logic [CRD_W-1:0]  ph, pw, ycrd, xcrd, ynext, xnext, yrel, xrel;
  logic [BW:0]       blocks;
  logic              active, inb;

  always_comb begin
    eoi = in_end_of_image;
    eor = eoi || in_end_of_row;
    eop = eor || in_end_of_pixel;

    ccnt_e = done_r ? '0 : ccnt_r;
    lcol_e = done_r ? '0 : lcol_r;
    lrow_e = done_r ? '0 : lrow_r;
    neg_e  = done_r ? '0 : neg_acc_r;
    nz_e   = done_r ? '0 : nz_acc_r;

    pix_ok = (lcol_e < MAX_COLS_V) && (lrow_e < MAX_ROWS_V);
    ch_ok  = ccnt_e < MAX_CH_V;
    mask   = WORD_BITS'(1) << ccnt_e[BIT_W-1:0];
    s_ext  = {in_sample[SAMPLE_W-1], in_sample};
    t_ext  = {2'b00, threshold_r};
    if (s_ext > t_ext) begin
      nz_e = nz_e | mask;
    end else if (s_ext < -t_ext) begin
      neg_e = neg_e | mask;
      nz_e  = nz_e | mask;
    end
    flush = ch_ok && (eop || (ccnt_e[BIT_W-1:0] == BIT_W'(WORD_BITS - 1))
                     || (ccnt_e == LAST_CH_V));

    wr_addr = {lrow_e[RW-1:0], lcol_e[CW-1:0], BW'(ccnt_e >> BIT_W)};
    wr_data = {nz_e, neg_e};
    mem_ctl.wr_en = load_acc && flush && pix_ok;
    mem_ctl.rd_en = pull_acc;

    // Pull geometry.
    ph     = CRD_W'(img_rows_r) + CRD_W'({g_pr_r, 1'b0});
    pw     = CRD_W'(img_cols_r) + CRD_W'({g_pc_r, 1'b0});
    blocks = (BW + 1)'((img_chans_r + CH_W'(WORD_BITS - 1)) >> BIT_W);
    active = done_r && !rdone_r && (g_kr_r != '0) && (g_kc_r != '0)
             && (ph >= CRD_W'(g_kr_r)) && (pw >= CRD_W'(g_kc_r)) && (blocks != '0);
    ycrd   = ybase_r + CRD_W'(kh_r);
    xcrd   = xbase_r + CRD_W'(kw_r);
    ynext  = ybase_r + CRD_W'(g_sr_r);
    xnext  = xbase_r + CRD_W'(g_sc_r);
    yrel   = ycrd - CRD_W'(g_pr_r);
    xrel   = xcrd - CRD_W'(g_pc_r);
    inb    = (ycrd >= CRD_W'(g_pr_r)) && (ycrd < CRD_W'(g_pr_r) + CRD_W'(img_rows_r))
          && (xcrd >= CRD_W'(g_pc_r)) && (xcrd < CRD_W'(g_pc_r) + CRD_W'(img_cols_r));
    rd_addr = {yrel[RW-1:0], xrel[CW-1:0], blk_r};
  end

  tqp_store #(.AW(AW)) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    neg_acc_nxt   = neg_acc_r;
    nz_acc_nxt    = nz_acc_r;
    ccnt_nxt      = ccnt_r;
    lcol_nxt      = lcol_r;
    lrow_nxt      = lrow_r;
    img_cols_nxt  = img_cols_r;
    img_rows_nxt  = img_rows_r;
    img_chans_nxt = img_chans_r;
    ovf_nxt       = ovf_r;
    done_nxt      = done_r;
    rdone_nxt     = rdone_r;
    ybase_nxt     = ybase_r;
    xbase_nxt     = xbase_r;
    kh_nxt        = kh_r;
    kw_nxt        = kw_r;
    blk_nxt       = blk_r;
    g_pr_nxt      = g_pr_r;
    g_pc_nxt      = g_pc_r;
    g_kr_nxt      = g_kr_r;
    g_kc_nxt      = g_kc_r;
    g_sr_nxt      = g_sr_r;
    g_sc_nxt      = g_sc_r;
    out_valid_nxt = out_valid_r && out_stall;
    hit_nxt       = hit_r;
    last_nxt      = last_r;
    exh_nxt       = exh_r;
    sovf_nxt      = sovf_r;

    if (load_acc) begin
      done_nxt  = 1'b0;
      rdone_nxt = done_r ? 1'b0 : rdone_r;
      ovf_nxt   = (done_r ? 1'b0 : ovf_r) || !pix_ok || !ch_ok;
      neg_acc_nxt = flush ? '0 : neg_e;
      nz_acc_nxt  = flush ? '0 : nz_e;
      ccnt_nxt    = ch_ok ? ccnt_e + CH_W'(1) : ccnt_e;
      lcol_nxt    = lcol_e;
      lrow_nxt    = lrow_e;
      if (eop) begin
        if (lcol_e == '0 && lrow_e == '0) begin
          img_chans_nxt = ccnt_nxt;
        end
        if (eor && lrow_e == '0) begin
          img_cols_nxt = (lcol_e < MAX_COLS_V) ? lcol_e + COLS_W'(1) : MAX_COLS_V;
        end
        ccnt_nxt    = '0;
        neg_acc_nxt = '0;
        nz_acc_nxt  = '0;
        if (eor) begin
          lcol_nxt = '0;
          if (eoi) begin
            img_rows_nxt = (lrow_e < MAX_ROWS_V) ? lrow_e + ROWS_W'(1) : MAX_ROWS_V;
          end
          if (lrow_e < MAX_ROWS_V) begin
            lrow_nxt = lrow_e + ROWS_W'(1);
          end
        end else if (lcol_e < MAX_COLS_V) begin
          lcol_nxt = lcol_e + COLS_W'(1);
        end
      end
      if (eoi) begin
        done_nxt  = 1'b1;
        rdone_nxt = 1'b0;
        lcol_nxt  = '0;
        lrow_nxt  = '0;
        g_pr_nxt  = pad_rows_r;
        g_pc_nxt  = pad_cols_r;
        g_kr_nxt  = (kern_rows_r > KCL_V) ? KCL_V : kern_rows_r;
        g_kc_nxt  = (kern_cols_r > KCL_V) ? KCL_V : kern_cols_r;
        g_sr_nxt  = (strd_rows_r == '0) ? GEOM_W'(1) : strd_rows_r;
        g_sc_nxt  = (strd_cols_r == '0) ? GEOM_W'(1) : strd_cols_r;
      end
      if (eoi || done_r) begin
        ybase_nxt = '0;
        xbase_nxt = '0;
        kh_nxt    = '0;
        kw_nxt    = '0;
        blk_nxt   = '0;
      end
    end

    if (pull_acc) begin
      out_valid_nxt = 1'b1;
      sovf_nxt      = ovf_r;
      exh_nxt       = !active;
      hit_nxt       = active && inb;
      last_nxt      = 1'b0;
      if (active) begin
        if ((BW + 1)'(blk_r) + (BW + 1)'(1) < blocks) begin
          blk_nxt = blk_r + BW'(1);
        end else begin
          blk_nxt = '0;
          if (kw_r + GEOM_W'(1) < g_kc_r) begin
            kw_nxt = kw_r + GEOM_W'(1);
          end else begin
            kw_nxt = '0;
            if (kh_r + GEOM_W'(1) < g_kr_r) begin
              kh_nxt = kh_r + GEOM_W'(1);
            end else begin
              kh_nxt = '0;
              if (xnext + CRD_W'(g_kc_r) <= pw) begin
                xbase_nxt = xnext;
              end else begin
                xbase_nxt = '0;
                if (ynext + CRD_W'(g_kr_r) <= ph) begin
                  ybase_nxt = ynext;
                end else begin
                  ybase_nxt = '0;
                  rdone_nxt = 1'b1;
                  last_nxt  = 1'b1;
                end
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
      pad_rows_r  <= '0;
      pad_cols_r  <= '0;
      kern_rows_r <= GEOM_W'(3);
      kern_cols_r <= GEOM_W'(3);
      strd_rows_r <= GEOM_W'(1);
      strd_cols_r <= GEOM_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD:   threshold_r <= cfg_data;
        REG_PAD_ROWS:    pad_rows_r  <= cfg_data[GEOM_W-1:0];
        REG_PAD_COLS:    pad_cols_r  <= cfg_data[GEOM_W-1:0];
        REG_KERNEL_ROWS: kern_rows_r <= cfg_data[GEOM_W-1:0];
        REG_KERNEL_COLS: kern_cols_r <= cfg_data[GEOM_W-1:0];
        REG_STRIDE_ROWS: strd_rows_r <= cfg_data[GEOM_W-1:0];
        REG_STRIDE_COLS: strd_cols_r <= cfg_data[GEOM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_acc_r   <= '0;
      nz_acc_r    <= '0;
      ccnt_r      <= '0;
      lcol_r      <= '0;
      lrow_r      <= '0;
      img_cols_r  <= '0;
      img_rows_r  <= '0;
      img_chans_r <= '0;
      ovf_r       <= 1'b0;
      done_r      <= 1'b0;
      rdone_r     <= 1'b0;
      ybase_r     <= '0;
      xbase_r     <= '0;
      kh_r        <= '0;
      kw_r        <= '0;
      blk_r       <= '0;
      g_pr_r      <= '0;
      g_pc_r      <= '0;
      g_kr_r      <= GEOM_W'(3);
      g_kc_r      <= GEOM_W'(3);
      g_sr_r      <= GEOM_W'(1);
      g_sc_r      <= GEOM_W'(1);
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      last_r      <= 1'b0;
      exh_r       <= 1'b0;
      sovf_r      <= 1'b0;
    end else begin
      neg_acc_r   <= neg_acc_nxt;
      nz_acc_r    <= nz_acc_nxt;
      ccnt_r      <= ccnt_nxt;
      lcol_r      <= lcol_nxt;
      lrow_r      <= lrow_nxt;
      img_cols_r  <= img_cols_nxt;
      img_rows_r  <= img_rows_nxt;
      img_chans_r <= img_chans_nxt;
      ovf_r       <= ovf_nxt;
      done_r      <= done_nxt;
      rdone_r     <= rdone_nxt;
      ybase_r     <= ybase_nxt;
      xbase_r     <= xbase_nxt;
      kh_r        <= kh_nxt;
      kw_r        <= kw_nxt;
      blk_r       <= blk_nxt;
      g_pr_r      <= g_pr_nxt;
      g_pc_r      <= g_pc_nxt;
      g_kr_r      <= g_kr_nxt;
      g_kc_r      <= g_kc_nxt;
      g_sr_r      <= g_sr_nxt;
      g_sc_r      <= g_sc_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
      last_r      <= last_nxt;
      exh_r       <= exh_nxt;
      sovf_r      <= sovf_nxt;
    end
  end

  // Positions in the padding read as zero words.
  assign out_valid         = out_valid_r;
  assign out_neg_plane     = hit_r ? rd_data[WORD_BITS-1:0] : '0;
  assign out_nonzero_plane = hit_r ? rd_data[2*WORD_BITS-1:WORD_BITS] : '0;
  assign out_last          = last_r;
  assign out_exhausted     = exh_r;
  assign out_size_overflow = sovf_r;

`ifndef NO_ASSERTIONS
  a_exh_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && exh_r |-> !last_r && !hit_r)
    else $error("exhausted beat carries data or last");

  a_rdone_done: assert property (@(posedge clk) disable iff (!rst_n)
    rdone_r |-> done_r)
    else $error("readout finished without a complete image");

  a_new_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pull_acc))
    else $error("beat appeared without an accepted pull");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    pull_acc && last_nxt |=> rdone_r)
    else $error("last beat did not end the readout");
`endif

endmodule

>>> rtl/tqp_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqp_store
// Pixel store: one write port for packed blocks, one registered read port.
// ----------------------------------------------------------------------------
module tqp_store import tqp_pkg::*; #(
  parameter int AW = 12
) (
  input  logic                   clk,
  input  mem_ctl_t               ctl,
  input  logic [AW-1:0]          wr_addr,
  input  logic [2*WORD_BITS-1:0] wr_data,
  input  logic [AW-1:0]          rd_addr,
  output logic [2*WORD_BITS-1:0] rd_data
);

  logic [2*WORD_BITS-1:0] mem [2**AW];
  logic [2*WORD_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
